// ===== hdl/utf8d_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8d_pkg
// shared types and codes of the utf-8 stream decoder: byte classes, the
// queued item format and the result status codes
// ----------------------------------------------------------------------------
package utf8d_pkg;

  // default width of the saturating character counter
  localparam int INDEX_BITS_DEFAULT = 32;

  // result status codes
  localparam logic [1:0] ST_VALID = 2'd0;
  localparam logic [1:0] ST_RAW   = 2'd1;
  localparam logic [1:0] ST_TRAIL = 2'd2;

  // byte class, settled once when the byte enters
  typedef enum logic [2:0] {
    CLS_ASCII,
    CLS_CONT,
    CLS_LEAD2,
    CLS_LEAD3,
    CLS_LEAD4,
    CLS_BAD
  } byte_class_t;

  // one queued byte with its class and end-of-string flag
  typedef struct packed {
    logic [7:0]  value;
    logic        last;
    byte_class_t cls;
  } item_t;

endpackage : utf8d_pkg
`default_nettype wire

// ===== hdl/utf8d_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8d_front
// accepts input bytes, classifies them by their leading one bits and holds
// them in a short queue for the decode side
// ----------------------------------------------------------------------------
module utf8d_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             byte_valid,
  output logic             byte_stall,
  input  logic [7:0]       byte_value,
  input  logic             last_byte,
  output logic             head_valid,
  output utf8d_pkg::item_t head,
  input  logic             head_pop
);
  import utf8d_pkg::*;

  localparam int Depth   = 4;
  localparam int PtrBits = $clog2(Depth);

  item_t              slots [Depth];
  logic [PtrBits-1:0] wr_ptr;
  logic [PtrBits-1:0] rd_ptr;
  logic [PtrBits:0]   count;
  logic               push;
  logic               pop;
  item_t              incoming;

  function automatic byte_class_t classify(input logic [7:0] b);
    byte_class_t c;
    unique casez (b)
      8'b0???????: c = CLS_ASCII;
      8'b10??????: c = CLS_CONT;
      8'b110?????: c = CLS_LEAD2;
      8'b1110????: c = CLS_LEAD3;
      8'b11110???: c = CLS_LEAD4;
      default:     c = CLS_BAD;
    endcase
    return c;
  endfunction

  assign byte_stall = (count == (PtrBits + 1)'(Depth));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];
  assign push       = byte_valid && !byte_stall;
  assign pop        = head_pop && head_valid;

  always_comb begin
    incoming.value = byte_value;
    incoming.last  = last_byte;
    incoming.cls   = classify(byte_value);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrBits'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrBits'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= incoming;
    end
  end

`ifndef SYNTHESIS
  a_count_range : assert property (@(posedge clk) disable iff (rst)
    count <= (PtrBits + 1)'(Depth))
    else $error("queue fill beyond depth");

  a_push_grow : assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1)
    else $error("queue fill did not grow on push");

  a_pop_shrink : assert property (@(posedge clk) disable iff (rst)
    pop && !push |=> count == $past(count) - 1'b1)
    else $error("queue fill did not shrink on pop");
`endif

endmodule : utf8d_front
`default_nettype wire

// ===== hdl/utf8d_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8d_back
// decodes one queued or replayed byte per cycle while the result port
// is not stalled: buffers multi-byte sequences, assembles code points,
// replays bytes after a bad continuation, drives the registered result port
// ----------------------------------------------------------------------------
module utf8d_back #(
  parameter int INDEX_BITS = utf8d_pkg::INDEX_BITS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  input  utf8d_pkg::item_t head,
  output logic             head_pop,
  output logic             result_valid,
  input  logic             result_stall,
  output logic [20:0]      code_point,
  output logic [1:0]       status,
  output logic [31:0]      char_index,
  output logic             last_result
);
  import utf8d_pkg::*;

  // replay list and sequence buffer
  item_t                  rq [3];
  logic [1:0]             rq_count;
  item_t                  pend [3];
  logic [1:0]             pcount;
  logic [2:0]             exp_len;
  logic [INDEX_BITS-1:0]  char_count;
  logic [INDEX_BITS-1:0]  char_next;

  item_t       cur;
  logic        from_rq;
  logic        out_ready;
  logic        step;
  logic        emit;
  logic [20:0] e_cp;
  logic [1:0]  e_st;
  logic        e_last;
  logic        do_start;
  logic        do_append;
  logic        do_clear;
  logic        do_replay;
  logic        string_end;
  logic        good;
  logic [20:0] joined;
  logic [1:0]  k;
  logic [1:0]  rest_count;
  item_t       rq_new [3];
  logic [1:0]  rq_new_count;

  function automatic logic [2:0] lead_len(input byte_class_t c);
    logic [2:0] n;
    unique case (c)
      CLS_LEAD2: n = 3'd2;
      CLS_LEAD3: n = 3'd3;
      default:   n = 3'd4;
    endcase
    return n;
  endfunction

  assign from_rq   = (rq_count != 2'd0);
  assign cur       = from_rq ? rq[0] : head;
  assign out_ready = !result_valid || !result_stall;
  assign step      = (from_rq || head_valid) && out_ready;
  assign head_pop  = step && !from_rq;
  assign char_next = (char_count == '1) ? char_count : char_count + 1'b1;

  // code point of a complete sequence
  always_comb begin
    case (exp_len)
      3'd2:    joined = {10'd0, pend[0].value[4:0], cur.value[5:0]};
      3'd3:    joined = {5'd0, pend[0].value[3:0], pend[1].value[5:0], cur.value[5:0]};
      default: joined = {pend[0].value[2:0], pend[1].value[5:0], pend[2].value[5:0],
                         cur.value[5:0]};
    endcase
  end

  // continuation check over the buffered bytes after the lead and the current one
  always_comb begin
    good = (cur.cls == CLS_CONT);
    for (int i = 1; i < 3; i++) begin
      if (2'(i) < pcount && pend[i].cls != CLS_CONT) begin
        good = 1'b0;
      end
    end
  end

  always_comb begin
    emit      = 1'b0;
    e_cp      = '0;
    e_st      = ST_VALID;
    e_last    = 1'b0;
    do_start  = 1'b0;
    do_append = 1'b0;
    do_clear  = 1'b0;
    do_replay = 1'b0;
    if (exp_len == 3'd0) begin
      case (cur.cls) inside
        CLS_ASCII: begin
          emit   = 1'b1;
          e_cp   = {13'd0, cur.value};
          e_last = cur.last;
        end
        CLS_LEAD2, CLS_LEAD3, CLS_LEAD4: begin
          if (cur.last) begin
            emit   = 1'b1;
            e_st   = ST_TRAIL;
            e_last = 1'b1;
          end else begin
            do_start = 1'b1;
          end
        end
        default: begin
          emit   = 1'b1;
          e_cp   = {13'd0, cur.value};
          e_st   = ST_RAW;
          e_last = cur.last;
        end
      endcase
    end else if ({1'b0, pcount} + 3'd1 < exp_len) begin
      if (cur.last) begin
        emit     = 1'b1;
        e_st     = ST_TRAIL;
        e_last   = 1'b1;
        do_clear = 1'b1;
      end else begin
        do_append = 1'b1;
      end
    end else begin
      emit     = 1'b1;
      do_clear = 1'b1;
      if (good) begin
        e_cp   = joined;
        e_last = cur.last;
      end else begin
        // lead byte goes out raw, the rest is decoded again
        e_cp      = {13'd0, pend[0].value};
        e_st      = ST_RAW;
        do_replay = 1'b1;
      end
    end
  end

  assign string_end = emit && e_last;

  // new replay list: buffered bytes after the lead, current byte, old rest
  assign k          = pcount - 2'd1;
  assign rest_count = from_rq ? rq_count - 2'd1 : 2'd0;
  assign rq_new_count = k + 2'd1 + rest_count;

  always_comb begin
    rq_new[0] = (k == 2'd0) ? cur : pend[1];
    rq_new[1] = (k == 2'd0) ? rq[1] : ((k == 2'd1) ? cur : pend[2]);
    rq_new[2] = (k == 2'd0) ? rq[2] : ((k == 2'd1) ? rq[1] : cur);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rq_count     <= 2'd0;
      pcount       <= 2'd0;
      exp_len      <= 3'd0;
      char_count   <= '0;
      result_valid <= 1'b0;
    end else begin
      if (out_ready) begin
        result_valid <= step && emit;
      end
      if (step) begin
        if (emit) begin
          char_count <= string_end ? '0 : char_next;
        end
        if (do_replay) begin
          rq_count <= rq_new_count;
        end else if (from_rq) begin
          rq_count <= rq_count - 2'd1;
        end
        if (do_clear) begin
          pcount  <= 2'd0;
          exp_len <= 3'd0;
        end else if (do_start) begin
          pcount  <= 2'd1;
          exp_len <= lead_len(cur.cls);
        end else if (do_append) begin
          pcount <= pcount + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      if (do_replay) begin
        rq[0] <= rq_new[0];
        rq[1] <= rq_new[1];
        rq[2] <= rq_new[2];
      end else if (from_rq) begin
        rq[0] <= rq[1];
        rq[1] <= rq[2];
      end
      if (do_start) begin
        pend[0] <= cur;
      end
      if (do_append) begin
        pend[pcount] <= cur;
      end
      if (emit) begin
        code_point  <= e_cp;
        status      <= e_st;
        char_index  <= 32'(char_next);
        last_result <= e_last;
      end
    end
  end

`ifndef SYNTHESIS
  a_buffer_room : assert property (@(posedge clk) disable iff (rst)
    {1'b0, pcount} + {1'b0, rq_count} <= 3'd3)
    else $error("sequence buffer and replay list overfilled");

  a_idle_empty : assert property (@(posedge clk) disable iff (rst)
    exp_len == 3'd0 |-> pcount == 2'd0)
    else $error("bytes buffered with no open sequence");

  a_partial_short : assert property (@(posedge clk) disable iff (rst)
    exp_len != 3'd0 |-> pcount != 2'd0 && {1'b0, pcount} < exp_len)
    else $error("open sequence holds a bad byte count");

  a_trail_form : assert property (@(posedge clk) disable iff (rst)
    result_valid && status == ST_TRAIL |-> last_result && code_point == 21'd0)
    else $error("trailing result not final or not zero");
`endif

endmodule : utf8d_back
`default_nettype wire

// ===== hdl/utf8_stream_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// utf-8 byte stream to code point decoder with per-string character index
// ----------------------------------------------------------------------------
// usage
//   input channel: byte_valid / byte_stall carry one item per byte, with
//   last_byte set on the final byte of a string. output channel:
//   result_valid / result_stall carry decoded items (code point, status,
//   one-based character index, last_result on the final item of a string).
//   an accepted item is written into the queue, then decoded into the
//   output register. throughput: one byte per cycle while no replay or
//   receiver stall holds the decoder; a sequence is given out when its
//   last byte is decoded, bytes inside a sequence give nothing. a bad
//   continuation byte makes the single decode unit replay the bytes after
//   the lead (up to three) one at a time before it takes new queue bytes.
//   the front queue holds four bytes, so input keeps flowing meanwhile.
//   receiver stall: the output register holds its item; decode stops, and
//   the input side stalls once the four-entry queue is full.
//   reset: clears the queue, any open sequence and the character count;
//   the first byte after reset starts a new string.
// ----------------------------------------------------------------------------
module utf8_stream_decoder #(
  parameter int INDEX_BITS = utf8d_pkg::INDEX_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // byte input
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  byte_value,
  input  logic        last_byte,
  // decoded output
  output logic        result_valid,
  input  logic        result_stall,
  output logic [20:0] code_point,
  output logic [1:0]  status,
  output logic [31:0] char_index,
  output logic        last_result
);
  import utf8d_pkg::*;

  // queue head between the classify front and the decode back
  logic  head_valid;
  logic  head_pop;
  item_t head;

  // front: accept, classify, queue
  utf8d_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_value (byte_value),
    .last_byte  (last_byte),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop)
  );

  // back: sequence buffer, assembly, replay, result register
  utf8d_back #(
    .INDEX_BITS (INDEX_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .head_pop     (head_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .code_point   (code_point),
    .status       (status),
    .char_index   (char_index),
    .last_result  (last_result)
  );

endmodule : utf8_stream_decoder
`default_nettype wire
